// ----- rtl/wcss_pkg.sv -----
package wcss_pkg;

	// fixed field widths of the channels
	localparam int LABEL_W    = 4;
	localparam int VALUE_W    = 16;
	localparam int CIDX_W     = 4;
	localparam int SSW_W      = 47;
	localparam int NF_W       = 4;
	localparam int NC_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// at most this many results per end of set
	localparam int RESULT_LIMIT = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd1;

endpackage

// ----- rtl/wcss_if.sv -----
interface wcss_item_if;
	import wcss_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [LABEL_W-1:0]        cluster_label;
	logic signed [VALUE_W-1:0] value;
	logic                      end_of_row;
	logic                      end_of_set;
	modport source (output valid, cluster_label, value, end_of_row, end_of_set, input ready);
	modport sink (input valid, cluster_label, value, end_of_row, end_of_set, output ready);
endinterface

interface wcss_result_if;
	import wcss_pkg::*;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] cluster_index;
	logic [SSW_W-1:0]  ssw;
	logic              last;
	modport source (output valid, cluster_index, ssw, last, input ready);
	modport sink (input valid, cluster_index, ssw, last, output ready);
endinterface

interface wcss_cfg_if;
	import wcss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/wcss_fifo.sv -----
module wcss_fifo import wcss_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;
	logic            push, pop;

	assign push_ready = (int'(cnt_q) < DEPTH);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (int'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (int'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- rtl/wcss_front.sv -----
module wcss_front import wcss_pkg::*; #(
	parameter int MC  = 16,
	parameter int MF  = 8,
	parameter int MS  = 4096,
	parameter int FW  = 3,
	parameter int FPW = 4,
	parameter int CW  = 13,
	parameter int EW  = 26
) (
	input  logic           clk,
	input  logic           arst_n,
	wcss_item_if.sink      sample,
	input  logic [FPW-1:0] nf,
	output logic           push_valid,
	input  logic           push_ready,
	output logic [EW-1:0]  push_data
);
	logic [FPW-1:0] pos_q;
	logic [CW-1:0]  rows_q;
	logic           take, label_ok, full, acc, cnt, is_set;

	always_comb begin
		is_set   = sample.end_of_set;
		take     = sample.valid && push_ready;
		label_ok = (int'(sample.cluster_label) < MC);
		full     = (int'(rows_q) >= MS);
		acc      = !is_set && !full && label_ok && (pos_q < nf);
		cnt      = !is_set && !full && label_ok && sample.end_of_row;
		sample.ready = push_ready;
		push_valid   = sample.valid && (is_set || acc || cnt);
		push_data    = {is_set, acc, cnt, sample.cluster_label, FW'(pos_q), sample.value};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rows_q <= '0;
		end else if (take) begin
			if (is_set) begin
				pos_q  <= '0;
				rows_q <= '0;
			end else if (!full) begin
				if (sample.end_of_row) begin
					pos_q <= '0;
					if (label_ok) begin
						rows_q <= rows_q + 1'b1;
					end
				end else if (int'(pos_q) < MF) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/wcss_div.sv -----
module wcss_div import wcss_pkg::*; #(
	parameter int DW = 56,
	parameter int NW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int KW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;
	logic [NW:0]   rem_q, rem_sh;
	logic [NW-1:0] div_q;
	logic [KW-1:0] cnt_q;
	logic          done_q, ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q[NW-1:0], dq_q[DW-1]};
		ge     = (rem_sh >= {1'b0, div_q});
	end

	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == KW'(1)) && !start;
			if (start) begin
				cnt_q <= KW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- rtl/wcss_back.sv -----
module wcss_back import wcss_pkg::*; #(
	parameter int MC  = 16,
	parameter int MF  = 8,
	parameter int FW  = 3,
	parameter int FPW = 4,
	parameter int CW  = 13,
	parameter int SW  = 28,
	parameter int SQW = 44,
	parameter int EW  = 26
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  logic [EW-1:0]   q_data,
	input  logic [FPW-1:0]  nf,
	input  logic [NC_W-1:0] nc,
	wcss_result_if.source   result
);
	localparam int DEPTH = MC * MF;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = (MC > 1) ? $clog2(MC) : 1;
	localparam int PW    = 2 * SW;
	localparam int MW    = (PW > SQW) ? PW : SQW;

	typedef enum logic [2:0] {
		ST_RUN, ST_CL, ST_RD, ST_MUL, ST_DIV, ST_WAIT, ST_OUT, ST_CLR
	} st_t;

	st_t st_q;

	logic signed [SW-1:0] sum_mem [DEPTH];
	logic [SQW-1:0]       sq_mem [DEPTH];
	logic signed [SW-1:0] rd_sum_q;
	logic [SQW-1:0]       rd_sq_q;
	logic [DEPTH-1:0]     vld_q;
	logic [CW-1:0]        cnt_q [MC];

	// queue head
	logic                      h_set, h_acc, h_cnt;
	logic [LABEL_W-1:0]        h_label;
	logic [FW-1:0]             h_pos;
	logic signed [VALUE_W-1:0] h_val;
	logic                      pop;
	logic [AW-1:0]             h_addr, w_addr, rd_addr;

	// accumulate stage
	logic                      s1_v, s1_acc, s1_cnt;
	logic [AW-1:0]             s1_addr;
	logic [LABEL_W-1:0]        s1_label;
	logic signed [VALUE_W-1:0] s1_val;
	logic                      fwd_v_q;
	logic [AW-1:0]             fwd_addr_q;
	logic signed [SW-1:0]      fwd_sum_q, base_sum, new_sum;
	logic [SQW-1:0]            fwd_sq_q, base_sq, new_sq;
	logic signed [2*VALUE_W-1:0] vsq;

	// walk
	logic [NC_W-1:0]      c_q;
	logic [FPW-1:0]       f_q;
	logic [CW-1:0]        n_q;
	logic [SSW_W-1:0]     total_q;
	logic [PW-1:0]        prod_q, div_quo;
	logic [SQW-1:0]       sq_q;
	logic signed [SW-1:0] w_sum;
	logic [SQW-1:0]       w_sq;
	logic [SW-1:0]        w_mag;
	logic                 div_done;

	logic                 out_v_q, out_last_q;
	logic [CIDX_W-1:0]    out_idx_q;
	logic [SSW_W-1:0]     out_ssw_q;

	always_comb begin
		h_set   = q_data[EW-1];
		h_acc   = q_data[EW-2];
		h_cnt   = q_data[EW-3];
		h_label = q_data[EW-4 -: LABEL_W];
		h_pos   = q_data[VALUE_W +: FW];
		h_val   = q_data[VALUE_W-1:0];
		h_addr  = AW'(int'(h_label) * MF + int'(h_pos));
		w_addr  = AW'(int'(c_q) * MF + int'(f_q));
		rd_addr = (st_q == ST_RUN) ? h_addr : w_addr;
		// a set request waits until the accumulate stage is empty
		q_ready = (st_q == ST_RUN) && (!h_set || !s1_v);
		pop     = q_valid && q_ready;

		if (fwd_v_q && (fwd_addr_q == s1_addr)) begin
			base_sum = fwd_sum_q;
			base_sq  = fwd_sq_q;
		end else if (vld_q[s1_addr]) begin
			base_sum = rd_sum_q;
			base_sq  = rd_sq_q;
		end else begin
			base_sum = '0;
			base_sq  = '0;
		end
		vsq     = s1_val * s1_val;
		new_sum = base_sum + {{(SW-VALUE_W){s1_val[VALUE_W-1]}}, s1_val};
		new_sq  = base_sq + {{(SQW-2*VALUE_W){1'b0}}, vsq};

		w_sum = vld_q[w_addr] ? rd_sum_q : '0;
		w_sq  = vld_q[w_addr] ? rd_sq_q : '0;
		w_mag = w_sum[SW-1] ? SW'(-w_sum) : w_sum;

		result.valid         = out_v_q;
		result.cluster_index = out_idx_q;
		result.ssw           = out_ssw_q;
		result.last          = out_last_q;
	end

	wcss_div #(.DW(PW), .NW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (st_q == ST_DIV),
		.dividend (prod_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sum stores
	always_ff @(posedge clk) begin
		rd_sum_q <= sum_mem[rd_addr];
		rd_sq_q  <= sq_mem[rd_addr];
		if (s1_v && s1_acc) begin
			sum_mem[s1_addr] <= new_sum;
			sq_mem[s1_addr]  <= new_sq;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			s1_acc   <= h_acc;
			s1_cnt   <= h_cnt;
			s1_addr  <= h_addr;
			s1_label <= h_label;
			s1_val   <= h_val;
		end
		fwd_addr_q <= s1_addr;
		fwd_sum_q  <= new_sum;
		fwd_sq_q   <= new_sq;
		if (st_q == ST_CL) begin
			n_q <= cnt_q[LW'(c_q)];
		end
		if (st_q == ST_MUL) begin
			prod_q <= PW'(w_mag) * PW'(w_mag);
			sq_q   <= w_sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_RUN;
			s1_v       <= 1'b0;
			fwd_v_q    <= 1'b0;
			vld_q      <= '0;
			c_q        <= '0;
			f_q        <= '0;
			total_q    <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
			out_idx_q  <= '0;
			out_ssw_q  <= '0;
			for (int i = 0; i < MC; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			fwd_v_q <= s1_v && s1_acc;
			s1_v    <= pop && !h_set;
			if (s1_v && s1_acc) begin
				vld_q[s1_addr] <= 1'b1;
			end
			if (s1_v && s1_cnt) begin
				cnt_q[LW'(s1_label)] <= cnt_q[LW'(s1_label)] + 1'b1;
			end
			// in ST_OUT an accepted result is always replaced by the next one
			if (result.valid && result.ready && (st_q != ST_OUT)) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_RUN: begin
					if (pop && h_set) begin
						c_q  <= '0;
						st_q <= ST_CL;
					end
				end
				ST_CL: begin
					f_q     <= '0;
					total_q <= '0;
					st_q    <= (cnt_q[LW'(c_q)] == '0) ? ST_OUT : ST_RD;
				end
				ST_RD:   st_q <= ST_MUL;
				ST_MUL:  st_q <= ST_DIV;
				ST_DIV:  st_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						if (MW'(sq_q) > MW'(div_quo)) begin
							total_q <= total_q + SSW_W'(MW'(sq_q) - MW'(div_quo));
						end
						f_q  <= f_q + 1'b1;
						st_q <= (f_q + 1'b1 == nf) ? ST_OUT : ST_RD;
					end
				end
				ST_OUT: begin
					if (!out_v_q || result.ready) begin
						out_v_q    <= 1'b1;
						out_idx_q  <= CIDX_W'(c_q);
						out_ssw_q  <= total_q;
						out_last_q <= (c_q + 1'b1 == nc);
						c_q        <= c_q + 1'b1;
						st_q       <= (c_q + 1'b1 == nc) ? ST_CLR : ST_CL;
					end
				end
				ST_CLR: begin
					vld_q <= '0;
					for (int i = 0; i < MC; i++) begin
						cnt_q[i] <= '0;
					end
					st_q <= ST_RUN;
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end
endmodule

// ----- rtl/within_cluster_sum_of_squares.sv -----
// channel  role    transaction
// -------  ------  ------------------------------------------------------------
// sample   sink    one feature value with label, end_of_row, end_of_set
// result   source  one per cluster after end of set: cluster_index, ssw, last
// cfg      sink    register write: index 0 num_features, 1 num_clusters
//
// data transactions are taken one per cycle while the queue has room; each
// value is added to its store entry in the cycle after it leaves the queue
// end of set walks the clusters: per feature the read, multiply, divide and wait
// states (one quotient bit per cycle in the divider), plus count load and output per cluster
// reset clears the stores at once through per-entry valid bits, no sweep
// a stalled result holds the walk; the queue lets the sample side run on until it is full
module within_cluster_sum_of_squares import wcss_pkg::*; #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_FEATURES = 8,
	parameter int MAX_SAMPLES  = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	wcss_item_if.sink     sample,
	wcss_result_if.source result,
	wcss_cfg_if.sink      cfg
);
	// feature position index and counter widths
	localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FPW = $clog2(MAX_FEATURES + 1);
	// row counts up to MAX_SAMPLES
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	// signed sum of Q8.8 values and sum of Q16.16 squares
	localparam int SW  = VALUE_W + $clog2(MAX_SAMPLES) + 1;
	localparam int SQW = 2 * VALUE_W + $clog2(MAX_SAMPLES);
	// queue entry: set, accumulate, count flags, label, position, value
	localparam int EW  = 3 + LABEL_W + FW + VALUE_W;
	localparam int NC_LIM = (MAX_CLUSTERS < RESULT_LIMIT) ? MAX_CLUSTERS : RESULT_LIMIT;

	logic [NF_W-1:0] nf_q;
	logic [NC_W-1:0] nc_q;
	logic [FPW-1:0]  nf_use;
	logic [NC_W-1:0] nc_use;

	logic          push_valid, push_ready, pop_valid, pop_ready;
	logic [EW-1:0] push_data, pop_data;

	assign cfg.ready = 1'b1;

	// registers are clamped to their usable range where they are used
	always_comb begin
		if (nf_q == '0) begin
			nf_use = FPW'(1);
		end else if (int'(nf_q) > MAX_FEATURES) begin
			nf_use = FPW'(MAX_FEATURES);
		end else begin
			nf_use = FPW'(nf_q);
		end
		if (nc_q == '0) begin
			nc_use = NC_W'(1);
		end else if (int'(nc_q) > NC_LIM) begin
			nc_use = NC_W'(NC_LIM);
		end else begin
			nc_use = nc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q <= NF_W'(8);
			nc_q <= NC_W'(16);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NUM_FEATURES: nf_q <= cfg.data[NF_W-1:0];
				REG_NUM_CLUSTERS: nc_q <= cfg.data[NC_W-1:0];
				default: ;
			endcase
		end
	end

	// front: classifies each sample transaction and queues the work
	wcss_front #(
		.MC(MAX_CLUSTERS), .MF(MAX_FEATURES), .MS(MAX_SAMPLES),
		.FW(FW), .FPW(FPW), .CW(CW), .EW(EW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.nf         (nf_use),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// short queue between the two sides
	wcss_fifo #(.W(EW), .DEPTH(4)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: store update and the end-of-set walk with divider
	wcss_back #(
		.MC(MAX_CLUSTERS), .MF(MAX_FEATURES), .FW(FW), .FPW(FPW),
		.CW(CW), .SW(SW), .SQW(SQW), .EW(EW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_data  (pop_data),
		.nf      (nf_use),
		.nc      (nc_use),
		.result  (result)
	);
endmodule
